>>> hw/rtl/bsc_pkg.sv
// shared widths, constants and types for the bit string compare block
package bsc_pkg;

	localparam int LEN_W = 13;
	localparam int CNT_W = 10;
	localparam int BYTE_W = 8;
	localparam int LZ_W = 3;
	localparam int NV_W = 4;

	// longest string length that counts; longer lengths are clamped
	localparam int MAX_BITS = 4096;
	localparam logic [CNT_W-1:0] COUNT_TOP = {CNT_W{1'b1}};

	localparam logic signed [1:0] ORD_LESS = 2'sb11;
	localparam logic signed [1:0] ORD_EQUAL = 2'sb00;
	localparam logic signed [1:0] ORD_GREATER = 2'sb01;

	typedef struct packed {
		logic hit;
		logic [LZ_W-1:0] lead;
		logic a_one;
	} byte_diff_t;

endpackage

>>> hw/rtl/bsc_byte_cmp.sv
// masked compare of one byte pair: first differing bit and which side holds the 1
module bsc_byte_cmp (
	input  logic [bsc_pkg::BYTE_W-1:0] a_byte,
	input  logic [bsc_pkg::BYTE_W-1:0] b_byte,
	input  logic [bsc_pkg::NV_W-1:0]   nvalid,
	output bsc_pkg::byte_diff_t        diff
);
	import bsc_pkg::*;

	logic [BYTE_W-1:0] mask;
	logic [BYTE_W-1:0] x;

	// keep the nvalid earliest bits; zero counted bits gives an empty mask
	assign mask = 8'hFF << (NV_W'(BYTE_W) - nvalid);
	assign x = (a_byte ^ b_byte) & mask;

	always_comb begin
		logic seen;
		seen = 1'b0;
		diff.hit = 1'b0;
		diff.lead = '0;
		diff.a_one = 1'b0;
		for (int i = 0; i < BYTE_W; i++) begin
			if (!seen && x[BYTE_W-1-i]) begin
				seen = 1'b1;
				diff.hit = 1'b1;
				diff.lead = LZ_W'(i);
				diff.a_one = a_byte[BYTE_W-1-i];
			end
		end
	end

endmodule

>>> hw/rtl/bit_string_compare.sv
// top level of the streamed lexicographic bit string compare
// Takes one byte pair of two MSB-first bit strings per cycle, with both bit lengths on every
// word, and on the word marked last gives one result: the order (-1, 0, 1) and the index of
// the first differing bit, or the shorter length when the counted bits all match. A word is
// accepted every cycle that the input register does not hold back; the result of a string
// passes through the input register into the result register and waits there until the consumer
// takes it. The input register holds back only when a last word meets a result that the
// consumer has not yet taken. Lengths above 4096 are clamped, and bytes past the shorter
// length are ignored.
module bit_string_compare (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [bsc_pkg::BYTE_W-1:0]   a_byte,
	input  logic [bsc_pkg::BYTE_W-1:0]   b_byte,
	input  logic [bsc_pkg::LEN_W-1:0]    a_len,
	input  logic [bsc_pkg::LEN_W-1:0]    b_len,
	input  logic                         last,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic signed [1:0]            order,
	output logic [bsc_pkg::LEN_W-1:0]    diff_pos
);
	import bsc_pkg::*;

	logic              valid_s1;
	logic [BYTE_W-1:0] a_byte_s1;
	logic [BYTE_W-1:0] b_byte_s1;
	logic [LEN_W-1:0]  a_len_s1;
	logic [LEN_W-1:0]  b_len_s1;
	logic              last_s1;

	logic [CNT_W-1:0]  byte_count_q;
	logic              found_q;
	logic signed [1:0] found_order_q;
	logic [LEN_W-1:0]  found_pos_q;

	logic              out_valid_q;
	logic signed [1:0] order_q;
	logic [LEN_W-1:0]  diff_pos_q;

	logic              adv;
	logic [LEN_W-1:0]  la;
	logic [LEN_W-1:0]  lb;
	logic [LEN_W-1:0]  m;
	logic [LEN_W-1:0]  start;
	logic [LEN_W-1:0]  remain;
	logic              in_range;
	logic [NV_W-1:0]   nvalid;
	byte_diff_t        diff;
	logic              new_hit;
	logic signed [1:0] new_order;
	logic [LEN_W-1:0]  new_pos;
	logic signed [1:0] res_order;
	logic [LEN_W-1:0]  res_pos;

	assign adv = valid_s1 && (!last_s1 || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			a_byte_s1 <= a_byte;
			b_byte_s1 <= b_byte;
			a_len_s1 <= a_len;
			b_len_s1 <= b_len;
			last_s1 <= last;
		end
	end

	always_comb begin
		la = (a_len_s1 > LEN_W'(MAX_BITS)) ? LEN_W'(MAX_BITS) : a_len_s1;
		lb = (b_len_s1 > LEN_W'(MAX_BITS)) ? LEN_W'(MAX_BITS) : b_len_s1;
		m = (la < lb) ? la : lb;
		start = {byte_count_q, 3'b000};
		in_range = !found_q && (start < m);
		remain = m - start;
		if (!in_range) begin
			nvalid = '0;
		end else if (remain >= LEN_W'(BYTE_W)) begin
			nvalid = NV_W'(BYTE_W);
		end else begin
			nvalid = remain[NV_W-1:0];
		end
	end

	bsc_byte_cmp u_byte_cmp (
		.a_byte (a_byte_s1),
		.b_byte (b_byte_s1),
		.nvalid (nvalid),
		.diff   (diff)
	);

	always_comb begin
		new_hit = found_q || diff.hit;
		new_order = found_q ? found_order_q : (diff.a_one ? ORD_GREATER : ORD_LESS);
		new_pos = found_q ? found_pos_q : (start + LEN_W'(diff.lead));
		if (new_hit) begin
			res_order = new_order;
			res_pos = new_pos;
		end else begin
			// no counted bit differs: the longer string wins
			res_order = (la > lb) ? ORD_GREATER : ((la < lb) ? ORD_LESS : ORD_EQUAL);
			res_pos = m;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q <= '0;
			found_q <= 1'b0;
			found_order_q <= ORD_EQUAL;
			found_pos_q <= '0;
		end else if (adv) begin
			if (last_s1) begin
				byte_count_q <= '0;
				found_q <= 1'b0;
				found_order_q <= ORD_EQUAL;
				found_pos_q <= '0;
			end else begin
				if (byte_count_q != COUNT_TOP) begin
					byte_count_q <= byte_count_q + CNT_W'(1);
				end
				found_q <= new_hit;
				if (!found_q && diff.hit) begin
					found_order_q <= new_order;
					found_pos_q <= new_pos;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && last_s1) begin
			order_q <= res_order;
			diff_pos_q <= res_pos;
		end
	end

	assign out_valid = out_valid_q;
	assign order = order_q;
	assign diff_pos = diff_pos_q;

endmodule
